// ===== sv/lkvs_pkg.sv =====
package lkvs_pkg;

    // Default sizes of the store
    localparam int ENTRIES_DEF    = 16;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    // Capacity register
    localparam int              CAP_W        = 5;
    localparam logic [CAP_W-1:0] CAP_RESET   = 5'd16;
    localparam logic [0:0]      REG_CAPACITY = 1'b0;

    // Request codes
    localparam logic [1:0] REQ_GET = 2'd0;
    localparam logic [1:0] REQ_PUT = 2'd1;
    localparam logic [1:0] REQ_DEL = 2'd2;

    // Result codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_NOTFOUND = 1'b1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] key;
        logic [31:0] value;
    } lkvs_req_t;

    typedef struct packed {
        logic        status;
        logic [31:0] read_value;
        logic [4:0]  entry_count;
    } lkvs_rsp_t;

    // Datapath operations
    typedef enum logic [2:0] {
        DP_NOP,
        DP_LOAD,
        DP_WALK,
        DP_TOUCH,
        DP_REMOVE_HIT,
        DP_REMOVE_LRU,
        DP_INSERT,
        DP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   write_value;
        logic   fail;
        logic   give_value;
    } lkvs_cmd_t;

    typedef struct packed {
        logic walk_last;
        logic hit;
        logic free_found;
        logic lru_found;
        logic full;
        logic out_free;
    } lkvs_stat_t;

endpackage

// ===== sv/lkvs_ctrl.sv =====
module lkvs_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_req_type,
    output lkvs_pkg::lkvs_cmd_t cmd,
    input  lkvs_pkg::lkvs_stat_t stat
);
    import lkvs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN,
        S_DECIDE,
        S_TOUCH,
        S_REMOVE_HIT,
        S_EVICT,
        S_INSERT,
        S_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] req_type_reg, req_type_next;
    logic       fail_reg, fail_next;
    logic       give_reg, give_next;

    // Sequence one request: walk, decide, update, emit
    always_comb begin
        state_next    = state_reg;
        req_type_next = req_type_reg;
        fail_next     = fail_reg;
        give_next     = give_reg;
        cmd.op          = DP_NOP;
        cmd.write_value = 1'b0;
        cmd.fail        = fail_reg;
        cmd.give_value  = give_reg;
        s_ready         = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op        = DP_LOAD;
                    req_type_next = s_req_type;
                    give_next     = 1'b0;
                    if (s_req_type == REQ_GET || s_req_type == REQ_PUT ||
                        s_req_type == REQ_DEL) begin
                        state_next = S_WALK;
                    end else begin
                        fail_next  = STATUS_NOTFOUND;
                        state_next = S_DONE;
                    end
                end
            end
            S_WALK: begin
                cmd.op = DP_WALK;
                if (stat.walk_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                fail_next  = STATUS_OK;
                give_next  = 1'b0;
                state_next = S_DONE;
                case (req_type_reg)
                    REQ_GET: begin
                        if (stat.hit) begin
                            give_next  = 1'b1;
                            state_next = S_TOUCH;
                        end else begin
                            fail_next = STATUS_NOTFOUND;
                        end
                    end
                    REQ_PUT: begin
                        if (stat.hit) begin
                            state_next = S_TOUCH;
                        end else if (stat.full && stat.lru_found) begin
                            state_next = S_EVICT;
                        end else if (stat.free_found) begin
                            state_next = S_INSERT;
                        end
                    end
                    REQ_DEL: begin
                        if (stat.hit) begin
                            state_next = S_REMOVE_HIT;
                        end else begin
                            fail_next = STATUS_NOTFOUND;
                        end
                    end
                    default: begin
                        fail_next = STATUS_NOTFOUND;
                    end
                endcase
            end
            S_TOUCH: begin
                cmd.op          = DP_TOUCH;
                cmd.write_value = (req_type_reg == REQ_PUT);
                state_next      = S_DONE;
            end
            S_REMOVE_HIT: begin
                cmd.op     = DP_REMOVE_HIT;
                state_next = S_DONE;
            end
            S_EVICT: begin
                cmd.op     = DP_REMOVE_LRU;
                state_next = S_INSERT;
            end
            S_INSERT: begin
                cmd.op     = DP_INSERT;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.op     = DP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and result flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            req_type_reg <= REQ_GET;
            fail_reg     <= STATUS_OK;
            give_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            req_type_reg <= req_type_next;
            fail_reg     <= fail_next;
            give_reg     <= give_next;
        end
    end

`ifndef SYNTH
    // A returned value only comes with a successful get
    a_give_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == DP_EMIT && cmd.give_value) |-> (req_type_reg == REQ_GET && !cmd.fail))
        else $error("value returned without a get hit");

    // An eviction is always followed by an insert
    a_evict_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EVICT) |=> (state_reg == S_INSERT))
        else $error("eviction not followed by insert");

    // The last walk step hands over to the compare drain
    a_walk_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK && stat.walk_last) |=> (state_reg == S_DRAIN))
        else $error("walk did not end in drain");
`endif

endmodule

// ===== sv/lkvs_datapath.sv =====
module lkvs_datapath #(
    parameter int ENTRIES    = lkvs_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = lkvs_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lkvs_pkg::VALUE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lkvs_pkg::lkvs_cmd_t           cmd,
    output lkvs_pkg::lkvs_stat_t          stat,
    input  logic [lkvs_pkg::CAP_W-1:0]    capacity,
    input  lkvs_pkg::lkvs_req_t           s_data,
    input  logic                          m_ready,
    output logic                          m_valid,
    output lkvs_pkg::lkvs_rsp_t           m_data
);
    import lkvs_pkg::*;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int RANK_W = IDX_W;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int EW     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // Key and value memories
    logic [KEY_BITS-1:0]   key_mem [ENTRIES];
    logic [VALUE_BITS-1:0] val_mem [ENTRIES];
    logic [KEY_BITS-1:0]   key_rd_reg;
    logic [VALUE_BITS-1:0] val_rd_reg;

    // Per-entry valid marks and recency ranks
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [RANK_W-1:0]  rank_reg  [ENTRIES];
    logic [RANK_W-1:0]  rank_next [ENTRIES];
    logic [CNT_W-1:0]   count_reg, count_next;

    // Request and walk state
    logic [KEY_BITS-1:0]   req_key_reg;
    logic [VALUE_BITS-1:0] req_val_reg;
    logic [IDX_W-1:0]      rd_addr_reg;
    logic                  cmp_valid_reg;
    logic [IDX_W-1:0]      cmp_idx_reg;

    // Search results
    logic                  hit_reg, free_found_reg, lru_found_reg, evicted_reg;
    logic [IDX_W-1:0]      hit_idx_reg, free_idx_reg, lru_idx_reg;
    logic [RANK_W-1:0]     hit_rank_reg, lru_rank_reg;
    logic [VALUE_BITS-1:0] hit_val_reg;

    // Result register
    logic      m_valid_reg;
    lkvs_rsp_t m_data_reg;

    logic              cmp_entry_valid;
    logic [RANK_W-1:0] cmp_rank;
    logic [IDX_W-1:0]  tgt_idx;
    logic [RANK_W-1:0] tgt_rank;
    logic [IDX_W-1:0]  ins_idx;
    logic [EW-1:0]     cap_ext, cnt_ext, ent_ext;

    assign cmp_entry_valid = valid_reg[cmp_idx_reg];
    assign cmp_rank        = rank_reg[cmp_idx_reg];

    // Pick remove target and insert slot
    assign tgt_idx  = (cmd.op == DP_REMOVE_LRU) ? lru_idx_reg : hit_idx_reg;
    assign tgt_rank = (cmd.op == DP_REMOVE_LRU) ? lru_rank_reg : hit_rank_reg;
    assign ins_idx  = (evicted_reg && (!free_found_reg || lru_idx_reg < free_idx_reg))
                      ? lru_idx_reg : free_idx_reg;

    // Compare count against effective capacity
    assign cap_ext = EW'(capacity);
    assign cnt_ext = EW'(count_reg);
    assign ent_ext = EW'(ENTRIES);

    always_comb begin
        stat.walk_last  = (rd_addr_reg == LAST_IDX);
        stat.hit        = hit_reg;
        stat.free_found = free_found_reg;
        stat.lru_found  = lru_found_reg;
        stat.out_free   = !m_valid_reg || m_ready;
        if (capacity == '0 || cap_ext > ent_ext) begin
            stat.full = (cnt_ext >= ent_ext);
        end else begin
            stat.full = (cnt_ext >= cap_ext);
        end
    end

    // Update every lane's valid mark and rank in parallel
    always_comb begin
        valid_next = valid_reg;
        count_next = count_reg;
        for (int i = 0; i < ENTRIES; i++) begin
            rank_next[i] = rank_reg[i];
            case (cmd.op)
                DP_TOUCH: begin
                    if (IDX_W'(i) == hit_idx_reg) begin
                        rank_next[i] = '0;
                    end else if (valid_reg[i] && rank_reg[i] < hit_rank_reg) begin
                        rank_next[i] = rank_reg[i] + 1'b1;
                    end
                end
                DP_REMOVE_HIT, DP_REMOVE_LRU: begin
                    if (IDX_W'(i) == tgt_idx) begin
                        valid_next[i] = 1'b0;
                        rank_next[i]  = '0;
                    end else if (valid_reg[i] && rank_reg[i] > tgt_rank) begin
                        rank_next[i] = rank_reg[i] - 1'b1;
                    end
                end
                DP_INSERT: begin
                    if (IDX_W'(i) == ins_idx) begin
                        valid_next[i] = 1'b1;
                        rank_next[i]  = '0;
                    end else if (valid_reg[i]) begin
                        rank_next[i] = rank_reg[i] + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        case (cmd.op)
            DP_REMOVE_HIT, DP_REMOVE_LRU: begin
                if (count_reg != '0) begin
                    count_next = count_reg - 1'b1;
                end
            end
            DP_INSERT: begin
                count_next = count_reg + 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                rank_reg[i] <= '0;
            end
        end else begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            for (int i = 0; i < ENTRIES; i++) begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    // Read memories at the walk address; write on insert or put hit
    always_ff @(posedge aclk) begin
        key_rd_reg <= key_mem[rd_addr_reg];
        val_rd_reg <= val_mem[rd_addr_reg];
        if (cmd.op == DP_INSERT) begin
            key_mem[ins_idx] <= req_key_reg;
            val_mem[ins_idx] <= req_val_reg;
        end else if (cmd.op == DP_TOUCH && cmd.write_value) begin
            val_mem[hit_idx_reg] <= req_val_reg;
        end
    end

    // Latch request payload
    always_ff @(posedge aclk) begin
        if (cmd.op == DP_LOAD) begin
            req_key_reg <= KEY_BITS'(s_data.key);
            req_val_reg <= VALUE_BITS'(s_data.value);
        end
    end

    // Walk address and compare stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_addr_reg   <= '0;
            cmp_valid_reg <= 1'b0;
        end else begin
            cmp_valid_reg <= (cmd.op == DP_WALK);
            if (cmd.op == DP_LOAD) begin
                rd_addr_reg <= '0;
            end else if (cmd.op == DP_WALK) begin
                rd_addr_reg <= (rd_addr_reg == LAST_IDX) ? '0 : rd_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmp_idx_reg <= rd_addr_reg;
    end

    // Track first hit, first free slot and least recent entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            lru_found_reg  <= 1'b0;
            evicted_reg    <= 1'b0;
        end else if (cmd.op == DP_LOAD) begin
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            lru_found_reg  <= 1'b0;
            evicted_reg    <= 1'b0;
        end else begin
            if (cmd.op == DP_REMOVE_LRU) begin
                evicted_reg <= 1'b1;
            end
            if (cmp_valid_reg) begin
                if (cmp_entry_valid && key_rd_reg == req_key_reg && !hit_reg) begin
                    hit_reg <= 1'b1;
                end
                if (!cmp_entry_valid && !free_found_reg) begin
                    free_found_reg <= 1'b1;
                end
                if (cmp_entry_valid && (!lru_found_reg || cmp_rank > lru_rank_reg)) begin
                    lru_found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmp_valid_reg) begin
            if (cmp_entry_valid && key_rd_reg == req_key_reg && !hit_reg) begin
                hit_idx_reg  <= cmp_idx_reg;
                hit_rank_reg <= cmp_rank;
                hit_val_reg  <= val_rd_reg;
            end
            if (!cmp_entry_valid && !free_found_reg) begin
                free_idx_reg <= cmp_idx_reg;
            end
            if (cmp_entry_valid && (!lru_found_reg || cmp_rank > lru_rank_reg)) begin
                lru_idx_reg  <= cmp_idx_reg;
                lru_rank_reg <= cmp_rank;
            end
        end
    end

    // Result register: load on emit, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.op == DP_EMIT) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == DP_EMIT) begin
            m_data_reg.status      <= cmd.fail;
            m_data_reg.read_value  <= cmd.give_value ? 32'(hit_val_reg) : 32'd0;
            m_data_reg.entry_count <= 5'(count_reg);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTH
    // Held count always equals the number of valid entries
    a_count_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_reg) == int'(count_reg))
        else $error("held count out of step with valid marks");

    // Insert never lands on an occupied slot
    a_insert_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == DP_INSERT) |-> !valid_reg[ins_idx])
        else $error("insert into occupied slot");

    // Touch and hit removal need a hit
    a_touch_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == DP_TOUCH || cmd.op == DP_REMOVE_HIT) |-> hit_reg)
        else $error("hit update without a hit");

    // Emit never overwrites a result that is still waiting
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == DP_EMIT) |-> (!m_valid_reg || m_ready))
        else $error("result overwritten while stalled");
`endif

endmodule

// ===== sv/lru_key_value_store_unit.sv =====
// LRU key-value store.
// Request beats arrive on s_valid/s_ready/s_data (get, put or delete with a
// key and a value); one result beat leaves on m_valid/m_ready/m_data for
// every request (status, read value on a get hit, entries held afterwards).
// The capacity register sits at byte address 0 of the APB-style port and
// must be written only while no request is in flight; the block does not
// enforce this. A request is taken only while the block is idle. Its lookup
// walks the key memory one entry per cycle, then recency ranks and the count
// are updated in parallel, with an eviction before the insert when the store
// is full. The next request is taken only after the result has been loaded
// into the output register.
// A request with an unknown code skips the walk and gets a not-found status.
// The result waits in an output register; a stalled receiver holds it there
// and a later request is accepted and processed but not released until the
// waiting beat is taken.
// Reset clears all valid marks, ranks and the count at once, and sets the
// capacity to 16. Key and value memories are not cleared.
module lru_key_value_store_unit #(
    parameter int ENTRIES    = lkvs_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = lkvs_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lkvs_pkg::VALUE_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lkvs_pkg::lkvs_req_t s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output lkvs_pkg::lkvs_rsp_t m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import lkvs_pkg::*;

    logic [CAP_W-1:0] cap_reg;
    lkvs_cmd_t        cmd;
    lkvs_stat_t       stat;

    // Capacity register write and read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (psel && penable && pwrite && paddr[2:2] == REG_CAPACITY) begin
            cap_reg <= pwdata[CAP_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2:2] == REG_CAPACITY) ? {{(32 - CAP_W){1'b0}}, cap_reg} : 32'd0;

    lkvs_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_data.req_type),
        .cmd        (cmd),
        .stat       (stat)
    );

    lkvs_datapath #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .capacity (cap_reg),
        .s_data   (s_data),
        .m_ready  (m_ready),
        .m_valid  (m_valid),
        .m_data   (m_data)
    );

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
    import lkvs_pkg::*;

    localparam int         SLOTS         = ENTRIES_DEF;
    localparam logic [1:0] REQ_IGNORED   = 2'd3;
    localparam logic [2:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};
    localparam int         STOP_AFTER    = 20_000_000;
    localparam int         PHASE_ITEMS   = 95;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    lkvs_req_t   s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    lkvs_rsp_t   m_data;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // Turn off idling on both sides during some phases
    bit steady = 1'b0;

    lru_key_value_store_unit i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Tracks the store contents and the expected response of each request
    class kv_tracker;
        logic [31:0]      key_mem[SLOTS];
        logic [31:0]      value_mem[SLOTS];
        bit               held[SLOTS];
        int               rank[SLOTS];
        int               count;
        logic [CAP_W-1:0] capacity;
        lkvs_rsp_t        pending_rsp[$];
        int               mismatches;

        function new();
            foreach (held[i]) begin
                held[i] = 1'b0;
                rank[i] = 0;
            end
            count      = 0;
            capacity   = CAP_RESET;
            mismatches = 0;
        endfunction

        function int find_slot(logic [31:0] k);
            for (int i = 0; i < SLOTS; i++)
                if (held[i] && key_mem[i] == k)
                    return i;
            return -1;
        endfunction

        // Move an entry to the front; younger entries age by one
        function void promote(int s);
            int r;
            r = rank[s];
            for (int i = 0; i < SLOTS; i++)
                if (held[i] && rank[i] < r)
                    rank[i]++;
            rank[s] = 0;
        endfunction

        function void drop_slot(int s);
            int r;
            r = rank[s];
            held[s] = 1'b0;
            rank[s] = 0;
            for (int i = 0; i < SLOTS; i++)
                if (held[i] && rank[i] > r)
                    rank[i]--;
            if (count > 0)
                count--;
        endfunction

        // Lowest index wins among equal ranks
        function int oldest_slot();
            int best;
            best = -1;
            for (int i = 0; i < SLOTS; i++)
                if (held[i] && (best < 0 || rank[i] > rank[best]))
                    best = i;
            return best;
        endfunction

        function int cap_limit();
            if (capacity == 0 || capacity > SLOTS)
                return SLOTS;
            return capacity;
        endfunction

        function void note_request(lkvs_req_t req);
            lkvs_rsp_t rsp;
            int        s;
            int        e;
            rsp.status     = STATUS_NOTFOUND;
            rsp.read_value = '0;
            case (req.req_type)
                REQ_GET: begin
                    s = find_slot(req.key);
                    if (s >= 0) begin
                        promote(s);
                        rsp.read_value = value_mem[s];
                        rsp.status     = STATUS_OK;
                    end
                end
                REQ_PUT: begin
                    rsp.status = STATUS_OK;
                    s = find_slot(req.key);
                    if (s >= 0) begin
                        value_mem[s] = req.value;
                        promote(s);
                    end else begin
                        // Evict a single entry even if capacity dropped further
                        if (count >= cap_limit()) begin
                            e = oldest_slot();
                            if (e >= 0)
                                drop_slot(e);
                        end
                        s = -1;
                        for (int i = 0; i < SLOTS; i++)
                            if (!held[i] && s < 0)
                                s = i;
                        if (s >= 0) begin
                            for (int i = 0; i < SLOTS; i++)
                                if (held[i])
                                    rank[i]++;
                            key_mem[s]   = req.key;
                            value_mem[s] = req.value;
                            held[s]      = 1'b1;
                            rank[s]      = 0;
                            count++;
                        end
                    end
                end
                REQ_DEL: begin
                    s = find_slot(req.key);
                    if (s >= 0) begin
                        drop_slot(s);
                        rsp.status = STATUS_OK;
                    end
                end
                default: ;
            endcase
            rsp.entry_count = 5'(count);
            pending_rsp.push_back(rsp);
        endfunction

        function void check_response(lkvs_rsp_t got);
            lkvs_rsp_t want;
            if (pending_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: status %0d value %h count %0d",
                             got.status, got.read_value, got.entry_count);
                return;
            end
            want = pending_rsp.pop_front();
            if (got.status !== want.status || got.read_value !== want.read_value ||
                got.entry_count !== want.entry_count) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %0d/%h/%0d, got %0d/%h/%0d",
                             want.status, want.read_value, want.entry_count,
                             got.status, got.read_value, got.entry_count);
            end
        endfunction
    endclass

    kv_tracker tracker;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Watch both channels at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                tracker.note_request(s_data);
            if (m_valid && m_ready)
                tracker.check_response(m_data);
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int draw_gap();
        int pick;
        if (steady)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return $urandom_range(0, 2);
        if (pick < 92)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic lkvs_req_t make_req(logic [1:0] kind, logic [31:0] k, logic [31:0] v);
        lkvs_req_t req;
        req.req_type = kind;
        req.key      = k;
        req.value    = v;
        return req;
    endfunction

    // Stall the result channel at random
    initial begin : rsp_stall
        int run;
        int hold;
        forever begin
            run = $urandom_range(1, 12);
            repeat (run) begin
                @(negedge aclk);
                m_ready = 1'b1;
            end
            hold = draw_gap();
            repeat (hold) begin
                @(negedge aclk);
                m_ready = 1'b0;
            end
        end
    end

    // Hold the beat until accepted
    task automatic send_request(input lkvs_req_t req);
        int gap;
        gap = draw_gap();
        repeat (gap) begin
            @(negedge aclk);
            s_valid = 1'b0;
        end
        @(negedge aclk);
        s_valid = 1'b1;
        s_data  = req;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid = 1'b0;
        while (tracker.pending_rsp.size() != 0)
            @(negedge aclk);
    endtask

    // Write capacity only while the store is idle
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        drain_results();
        repeat (8) @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = CAPACITY_ADDR;
        pwdata  = 32'(cap);
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        tracker.capacity = cap;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Random traffic over a key pool a little larger than the capacity
    task automatic run_phase(input logic [CAP_W-1:0] cap, input bit calm);
        logic [31:0] pool[SLOTS+6];
        int          span;
        int          pick;
        lkvs_req_t   req;
        write_capacity(cap);
        steady = calm;
        span = (cap == 0 || cap > SLOTS) ? SLOTS : cap;
        span = span + $urandom_range(1, 5);
        for (int i = 0; i < span; i++)
            pool[i] = $urandom;
        if ($urandom_range(0, 3) == 0)
            pool[0] = '0;
        if ($urandom_range(0, 3) == 0)
            pool[1] = '1;
        repeat (PHASE_ITEMS) begin
            // Pause now and then until every response is back
            if ($urandom_range(0, 99) == 0)
                drain_results();
            pick = $urandom_range(0, 99);
            req.req_type = pick < 45 ? REQ_PUT :
                           pick < 80 ? REQ_GET :
                           pick < 95 ? REQ_DEL : REQ_IGNORED;
            req.key   = ($urandom_range(0, 19) == 0) ? $urandom
                                                     : pool[$urandom_range(0, span - 1)];
            req.value = $urandom;
            send_request(req);
        end
    endtask

    initial begin : stimulus
        logic [CAP_W-1:0] caps[10];
        tracker = new();
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        // Empty store, ignored code, extreme keys and values, update in place
        send_request(make_req(REQ_GET, '0, '0));
        send_request(make_req(REQ_DEL, '0, '0));
        send_request(make_req(REQ_IGNORED, '0, '1));
        send_request(make_req(REQ_PUT, '0, '1));
        send_request(make_req(REQ_PUT, '1, '0));
        send_request(make_req(REQ_GET, '0, '0));
        send_request(make_req(REQ_GET, '1, '1));
        send_request(make_req(REQ_PUT, '0, 32'hA5A5_5A5A));
        send_request(make_req(REQ_GET, '0, '0));
        send_request(make_req(REQ_IGNORED, '0, '0));
        send_request(make_req(REQ_DEL, '1, '0));
        send_request(make_req(REQ_GET, '1, '0));
        send_request(make_req(REQ_DEL, '1, '0));

        // Eviction of the least recent entry at capacity two
        write_capacity(5'd2);
        send_request(make_req(REQ_PUT, 32'd1, 32'h0000_1111));
        send_request(make_req(REQ_GET, '0, '0));
        send_request(make_req(REQ_PUT, 32'd2, 32'h0000_2222));
        send_request(make_req(REQ_GET, 32'd1, '0));
        send_request(make_req(REQ_GET, 32'd2, '0));

        // Capacity below the count: one eviction per new key
        write_capacity(5'd1);
        send_request(make_req(REQ_PUT, 32'd3, 32'h0000_3333));
        send_request(make_req(REQ_GET, '0, '0));
        send_request(make_req(REQ_GET, 32'd3, '0));

        // Cover zero, one, full, above the entry count, and lowered below the count
        caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd17, 5'd8, 5'd16, 5'd2, 5'd0};
        caps[9] = 5'($urandom_range(0, 31));
        foreach (caps[p])
            run_phase(caps[p], p % 4 == 2);

        steady = 1'b0;
        drain_results();
        repeat (30) @(negedge aclk);
        if (tracker.mismatches == 0 && tracker.pending_rsp.size() == 0)
            $display("PASS lru_key_value_store_unit");
        else
            $display("FAIL lru_key_value_store_unit");
        $finish;
    end

    initial begin : watchdog
        #(STOP_AFTER);
        $display("FAIL lru_key_value_store_unit");
        $finish;
    end

endmodule
